// ===== rtl/spi_nor_flash_command_sequencer_macros.svh =====
// assertion macros for the spi nor flash command sequencer
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_MACROS_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SFCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SFCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sfcs_pkg.sv =====
// types, opcodes and helpers shared by the command sequencer files
package sfcs_pkg;

    // default geometry
    localparam int FLASH_BYTES_DEF  = 4194304;
    localparam int PAGE_BYTES_DEF   = 256;
    localparam int SECTOR_BYTES_DEF = 4096;
    localparam int BLOCK_BYTES_DEF  = 32768;

    // up to five header bytes per request
    localparam int MAX_ITEMS = 5;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W     = $clog2(MAX_ITEMS);

    // request kinds
    localparam logic [3:0] KIND_WREN        = 4'd0;
    localparam logic [3:0] KIND_READ        = 4'd1;
    localparam logic [3:0] KIND_FAST_READ   = 4'd2;
    localparam logic [3:0] KIND_PROGRAM     = 4'd3;
    localparam logic [3:0] KIND_PART_PROG   = 4'd4;
    localparam logic [3:0] KIND_SECT_ERASE  = 4'd5;
    localparam logic [3:0] KIND_BLOCK_ERASE = 4'd6;
    localparam logic [3:0] KIND_CHIP_ERASE  = 4'd7;
    localparam logic [3:0] KIND_STATUS      = 4'd8;
    localparam logic [3:0] KIND_ID          = 4'd9;
    localparam logic [3:0] KIND_ENTER_PD    = 4'd10;
    localparam logic [3:0] KIND_RELEASE_PD  = 4'd11;
    localparam logic [3:0] KIND_POWER_LOST  = 4'd12;

    // spi opcodes
    localparam logic [7:0] CMD_WREN        = 8'h06;
    localparam logic [7:0] CMD_READ        = 8'h03;
    localparam logic [7:0] CMD_FAST_READ   = 8'h0B;
    localparam logic [7:0] CMD_PROGRAM     = 8'h02;
    localparam logic [7:0] CMD_SECT_ERASE  = 8'h20;
    localparam logic [7:0] CMD_BLOCK_ERASE = 8'h52;
    localparam logic [7:0] CMD_CHIP_ERASE  = 8'hC7;
    localparam logic [7:0] CMD_ENTER_PD    = 8'hB9;
    localparam logic [7:0] CMD_RELEASE_PD  = 8'hAB;
    localparam logic [7:0] CMD_READ_ID     = 8'h9F;
    localparam logic [7:0] CMD_STATUS1     = 8'h05;
    localparam logic [7:0] CMD_STATUS2     = 8'h35;
    localparam logic [7:0] CMD_STATUS3     = 8'h15;
    localparam logic [7:0] CMD_DUMMY       = 8'h00;

    // data phase direction
    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_READ  = 2'd1;
    localparam logic [1:0] DIR_WRITE = 2'd2;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef struct packed {
        logic [3:0]  kind;
        logic [23:0] address;
        logic [15:0] length;
    } t_req;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  tx_byte;
        logic        frame_end;
        logic [15:0] data_len;
        logic [1:0]  data_dir;
        logic        result_status;
        logic        last;
    } t_rsp;

    typedef t_rsp [MAX_ITEMS-1:0] t_items;

    // decoded request: result list and its length
    typedef struct packed {
        t_items           items;
        logic [CNT_W-1:0] count;
    } t_plan;

    // emitter status seen by the top level
    typedef struct packed {
        logic busy;
        logic done;
    } t_emit_stat;

    function automatic t_rsp mk_byte(logic [7:0] b, logic fend, logic [15:0] dlen,
                                     logic [1:0] dir);
        t_rsp r;
        r.byte_valid    = 1'b1;
        r.tx_byte       = b;
        r.frame_end     = fend;
        r.data_len      = dlen;
        r.data_dir      = dir;
        r.result_status = STATUS_OK;
        r.last          = 1'b0;
        return r;
    endfunction

    function automatic t_rsp mk_empty(logic status);
        t_rsp r;
        r               = '0;
        r.result_status = status;
        return r;
    endfunction

    // command byte, three address bytes, optional dummy byte
    function automatic t_items addr_frame(logic [7:0] cmd, logic [23:0] addr, logic dummy,
                                          logic [15:0] dlen, logic [1:0] dir);
        t_items f;
        f    = '0;
        f[0] = mk_byte(cmd, 1'b0, dlen, dir);
        f[1] = mk_byte(addr[23:16], 1'b0, dlen, dir);
        f[2] = mk_byte(addr[15:8], 1'b0, dlen, dir);
        f[3] = mk_byte(addr[7:0], !dummy, dlen, dir);
        if (dummy) begin
            f[4] = mk_byte(CMD_DUMMY, 1'b1, dlen, dir);
        end
        return f;
    endfunction

endpackage

// ===== rtl/spi_nor_flash_command_sequencer.sv =====
// top level of the spi nor flash command sequencer
//
// Takes one flash request per input transaction (kind, 24-bit address, length),
// checks it against the flash geometry and returns the SPI header bytes of its
// frames as output transactions, one byte per transaction, in bus order; a
// rejected request returns one byte-less transaction with result_status set,
// and last marks the final transaction of every request. A request is checked
// and expanded in the cycle it is accepted and lands in a holding register;
// from there one result per cycle moves into the output register while the
// output is not stalled. A request has 1 to 5 results (5 for program, partial
// program, sector erase, block erase and fast read), and the next request is
// accepted in the cycle its predecessor's final result moves out. The first
// result passes through the holding register and then the output register.
module spi_nor_flash_command_sequencer #(
    parameter int FLASH_BYTES  = sfcs_pkg::FLASH_BYTES_DEF,
    parameter int PAGE_BYTES   = sfcs_pkg::PAGE_BYTES_DEF,
    parameter int SECTOR_BYTES = sfcs_pkg::SECTOR_BYTES_DEF,
    parameter int BLOCK_BYTES  = sfcs_pkg::BLOCK_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sfcs_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sfcs_pkg::t_rsp o_out_data
);
    import sfcs_pkg::*;

`include "spi_nor_flash_command_sequencer_macros.svh"

    // a request transaction completes here
    logic       take;
    // decoded result list for the request at the input
    t_plan      plan;
    // emitter holding-register state
    t_emit_stat stat;

    assign take = i_in_valid && o_in_ready;

    // checks plus header build; also owns the power-down armed flag
    sfcs_decode #(
        .FLASH_BYTES  (FLASH_BYTES),
        .PAGE_BYTES   (PAGE_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES),
        .BLOCK_BYTES  (BLOCK_BYTES)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_req   (i_in_data),
        .o_plan  (plan)
    );

    // one result per cycle into the output register while the output is not stalled
    sfcs_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_plan      (plan),
        .o_in_ready  (o_in_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // a byte-less result is always the only one of its request
    `SFCS_ASSERT_IMPLY(a_empty_is_last, i_clk, i_rst_n,
        o_out_valid && !o_out_data.byte_valid, o_out_data.last,
        "byte-less result without last")

    // a rejection never carries a bus byte
    `SFCS_ASSERT_IMPLY(a_reject_no_byte, i_clk, i_rst_n,
        o_out_valid && o_out_data.result_status, !o_out_data.byte_valid,
        "rejected request carries a byte")

    // an accepted request always leaves the holder busy
    `SFCS_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n,
        take, stat.busy,
        "accepted request not held")

endmodule

// ===== rtl/sfcs_decode.sv =====
// request checker and header builder with the power-down flag
module sfcs_decode #(
    parameter int FLASH_BYTES  = sfcs_pkg::FLASH_BYTES_DEF,
    parameter int PAGE_BYTES   = sfcs_pkg::PAGE_BYTES_DEF,
    parameter int SECTOR_BYTES = sfcs_pkg::SECTOR_BYTES_DEF,
    parameter int BLOCK_BYTES  = sfcs_pkg::BLOCK_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  sfcs_pkg::t_req  i_req,
    output sfcs_pkg::t_plan o_plan
);
    import sfcs_pkg::*;

    localparam logic [24:0] FLASH_L     = 25'(FLASH_BYTES);
    localparam logic [23:0] PAGE_MASK   = 24'(PAGE_BYTES - 1);
    localparam logic [16:0] PAGE_L      = 17'(PAGE_BYTES);
    localparam logic [23:0] SECT_MASK   = 24'(SECTOR_BYTES - 1);
    localparam logic [23:0] BLOCK_MASK  = 24'(BLOCK_BYTES - 1);
    localparam bit          BLOCK_FITS  = (BLOCK_BYTES <= FLASH_BYTES);
    localparam logic [24:0] BLOCK_LIMIT =
        BLOCK_FITS ? 25'(FLASH_BYTES - BLOCK_BYTES) : 25'd0;

    logic        r_armed;
    logic        n_armed;
    logic [24:0] addr_l;
    logic [24:0] addr_end;
    logic [16:0] page_end;
    logic        in_flash;
    logic        ok;
    t_rsp        wren;
    t_items      frame;

    assign addr_l   = {1'b0, i_req.address};
    assign addr_end = addr_l + {9'd0, i_req.length};
    assign page_end = 17'(i_req.address & PAGE_MASK) + {1'b0, i_req.length};
    assign in_flash = (addr_l < FLASH_L) && (addr_end <= FLASH_L);
    assign wren     = mk_byte(CMD_WREN, 1'b1, 16'd0, DIR_NONE);

    always_comb begin
        o_plan  = '0;
        ok      = 1'b1;
        n_armed = r_armed;
        frame   = '0;
        unique case (i_req.kind)
            KIND_WREN: begin
                o_plan.items[0] = wren;
                o_plan.count    = CNT_W'(1);
            end
            KIND_READ, KIND_FAST_READ: begin
                ok    = (i_req.length != 16'd0) && in_flash;
                frame = addr_frame((i_req.kind == KIND_READ) ? CMD_READ : CMD_FAST_READ,
                                   i_req.address, i_req.kind == KIND_FAST_READ,
                                   i_req.length, DIR_READ);
                o_plan.items = frame;
                o_plan.count = (i_req.kind == KIND_READ) ? CNT_W'(4) : CNT_W'(5);
            end
            KIND_PROGRAM, KIND_PART_PROG: begin
                if (i_req.kind == KIND_PROGRAM) begin
                    ok = ({1'b0, i_req.length} == PAGE_L)
                        && ((i_req.address & PAGE_MASK) == 24'd0) && in_flash;
                end else begin
                    ok = (i_req.length != 16'd0) && ({1'b0, i_req.length} <= PAGE_L)
                        && (page_end <= PAGE_L) && in_flash;
                end
                frame = addr_frame(CMD_PROGRAM, i_req.address, 1'b0, i_req.length,
                                   DIR_WRITE);
                o_plan.items = t_items'({frame[3:0], wren});
                o_plan.count = CNT_W'(5);
            end
            KIND_SECT_ERASE, KIND_BLOCK_ERASE: begin
                if (i_req.kind == KIND_SECT_ERASE) begin
                    ok = ((i_req.address & SECT_MASK) == 24'd0) && (addr_l < FLASH_L);
                end else begin
                    ok = BLOCK_FITS && ((i_req.address & BLOCK_MASK) == 24'd0)
                        && (addr_l <= BLOCK_LIMIT);
                end
                frame = addr_frame((i_req.kind == KIND_SECT_ERASE) ? CMD_SECT_ERASE
                                                                    : CMD_BLOCK_ERASE,
                                   i_req.address, 1'b0, 16'd0, DIR_NONE);
                o_plan.items = t_items'({frame[3:0], wren});
                o_plan.count = CNT_W'(5);
            end
            KIND_CHIP_ERASE: begin
                o_plan.items[0] = wren;
                o_plan.items[1] = mk_byte(CMD_CHIP_ERASE, 1'b1, 16'd0, DIR_NONE);
                o_plan.count    = CNT_W'(2);
            end
            KIND_STATUS: begin
                o_plan.items[0] = mk_byte(CMD_STATUS1, 1'b1, 16'd1, DIR_READ);
                o_plan.items[1] = mk_byte(CMD_STATUS2, 1'b1, 16'd1, DIR_READ);
                o_plan.items[2] = mk_byte(CMD_STATUS3, 1'b1, 16'd1, DIR_READ);
                o_plan.count    = CNT_W'(3);
            end
            KIND_ID: begin
                o_plan.items[0] = mk_byte(CMD_READ_ID, 1'b1, 16'd3, DIR_READ);
                o_plan.count    = CNT_W'(1);
            end
            KIND_ENTER_PD: begin
                // repeated entry is dropped from the bus
                if (r_armed) begin
                    o_plan.items[0] = mk_empty(STATUS_OK);
                end else begin
                    o_plan.items[0] = mk_byte(CMD_ENTER_PD, 1'b1, 16'd0, DIR_NONE);
                    n_armed         = 1'b1;
                end
                o_plan.count = CNT_W'(1);
            end
            KIND_RELEASE_PD: begin
                o_plan.items[0] = mk_byte(CMD_RELEASE_PD, 1'b1, 16'd0, DIR_NONE);
                o_plan.count    = CNT_W'(1);
                n_armed         = 1'b0;
            end
            KIND_POWER_LOST: begin
                o_plan.items[0] = mk_empty(STATUS_OK);
                o_plan.count    = CNT_W'(1);
                n_armed         = 1'b0;
            end
            default: begin
                ok = 1'b0;
            end
        endcase

        if (!ok) begin
            o_plan          = '0;
            o_plan.items[0] = mk_empty(STATUS_INVALID);
            o_plan.count    = CNT_W'(1);
            n_armed         = r_armed;
        end

        for (int i = 0; i < MAX_ITEMS; i++) begin
            o_plan.items[i].last = (CNT_W'(i) == (o_plan.count - CNT_W'(1)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
        end else if (i_take) begin
            r_armed <= n_armed;
        end
    end

endmodule

// ===== rtl/sfcs_emit.sv =====
// holds one decoded request and sends its results through the output register
module sfcs_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  sfcs_pkg::t_plan    i_plan,
    output logic               o_in_ready,
    output sfcs_pkg::t_emit_stat o_stat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sfcs_pkg::t_rsp     o_out_data
);
    import sfcs_pkg::*;

    t_items           r_items;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_idx;
    logic             r_busy;
    logic             r_out_valid;
    t_rsp             r_out;
    logic             out_load;
    logic             step;
    logic             done;

    assign out_load   = !r_out_valid || i_out_ready;
    assign step       = r_busy && out_load;
    assign done       = step && (CNT_W'(r_idx) == (r_count - CNT_W'(1)));
    assign o_in_ready = !r_busy || done;
    assign o_stat     = '{busy: r_busy, done: done};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_take) begin
            r_busy <= 1'b1;
        end else if (done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_items <= i_plan.items;
            r_count <= i_plan.count;
            r_idx   <= '0;
        end else if (step) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= r_items[r_idx];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== verif/flash_header_checker.sv =====
// checker for the flash command sequencer: predicts header bytes and compares each result
module flash_header_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_ready,
    input  sfcs_pkg::t_req i_req,
    input  logic           i_hdr_valid,
    input  logic           i_hdr_ready,
    input  sfcs_pkg::t_rsp i_hdr,
    output int             o_fail_count,
    output int             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sfcs_pkg::*;

    localparam int unsigned FLASH  = FLASH_BYTES_DEF;
    localparam int unsigned PAGE   = PAGE_BYTES_DEF;
    localparam int unsigned SECTOR = SECTOR_BYTES_DEF;
    localparam int unsigned BLOCK  = BLOCK_BYTES_DEF;

    t_rsp expected_hdrs[$];
    t_rsp req_hdrs[$];
    logic pd_armed   = 1'b0;
    int   fail_count = 0;
    int   pending    = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    function automatic void add_byte(logic [7:0] b, logic fend, logic [15:0] dlen,
                                     logic [1:0] dir);
        t_rsp h;
        h            = '0;
        h.byte_valid = 1'b1;
        h.tx_byte    = b;
        h.frame_end  = fend;
        h.data_len   = dlen;
        h.data_dir   = dir;
        req_hdrs.push_back(h);
    endfunction

    function automatic void add_empty(logic status);
        t_rsp h;
        h               = '0;
        h.result_status = status;
        req_hdrs.push_back(h);
    endfunction

    // opcode, address high byte first, optional dummy byte closing the frame
    function automatic void add_addr_frame(logic [7:0] cmd, logic [23:0] addr, logic dummy,
                                           logic [15:0] dlen, logic [1:0] dir);
        add_byte(cmd, 1'b0, dlen, dir);
        add_byte(addr[23:16], 1'b0, dlen, dir);
        add_byte(addr[15:8], 1'b0, dlen, dir);
        add_byte(addr[7:0], !dummy, dlen, dir);
        if (dummy) begin
            add_byte(CMD_DUMMY, 1'b1, dlen, dir);
        end
    endfunction

    function automatic void predict_headers(t_req req);
        int unsigned a;
        int unsigned n;
        bit          in_flash;
        bit          ok;
        t_rsp        h;
        a        = req.address;
        n        = req.length;
        in_flash = (a < FLASH) && (n <= FLASH - a);
        ok       = 1'b1;
        req_hdrs.delete();
        case (req.kind)
            KIND_WREN: add_byte(CMD_WREN, 1'b1, 16'd0, DIR_NONE);
            KIND_READ, KIND_FAST_READ: begin
                if (n == 0 || !in_flash) begin
                    ok = 1'b0;
                end else begin
                    add_addr_frame((req.kind == KIND_READ) ? CMD_READ : CMD_FAST_READ,
                                   req.address, req.kind == KIND_FAST_READ,
                                   req.length, DIR_READ);
                end
            end
            KIND_PROGRAM: begin
                if (n != PAGE || (a % PAGE) != 0 || !in_flash) begin
                    ok = 1'b0;
                end else begin
                    add_byte(CMD_WREN, 1'b1, 16'd0, DIR_NONE);
                    add_addr_frame(CMD_PROGRAM, req.address, 1'b0, req.length, DIR_WRITE);
                end
            end
            KIND_PART_PROG: begin
                if (n == 0 || n > PAGE || (a % PAGE) + n > PAGE || !in_flash) begin
                    ok = 1'b0;
                end else begin
                    add_byte(CMD_WREN, 1'b1, 16'd0, DIR_NONE);
                    add_addr_frame(CMD_PROGRAM, req.address, 1'b0, req.length, DIR_WRITE);
                end
            end
            KIND_SECT_ERASE: begin
                if ((a % SECTOR) != 0 || a >= FLASH) begin
                    ok = 1'b0;
                end else begin
                    add_byte(CMD_WREN, 1'b1, 16'd0, DIR_NONE);
                    add_addr_frame(CMD_SECT_ERASE, req.address, 1'b0, 16'd0, DIR_NONE);
                end
            end
            KIND_BLOCK_ERASE: begin
                if (BLOCK > FLASH || (a % BLOCK) != 0 || a > FLASH - BLOCK) begin
                    ok = 1'b0;
                end else begin
                    add_byte(CMD_WREN, 1'b1, 16'd0, DIR_NONE);
                    add_addr_frame(CMD_BLOCK_ERASE, req.address, 1'b0, 16'd0, DIR_NONE);
                end
            end
            KIND_CHIP_ERASE: begin
                add_byte(CMD_WREN, 1'b1, 16'd0, DIR_NONE);
                add_byte(CMD_CHIP_ERASE, 1'b1, 16'd0, DIR_NONE);
            end
            KIND_STATUS: begin
                add_byte(CMD_STATUS1, 1'b1, 16'd1, DIR_READ);
                add_byte(CMD_STATUS2, 1'b1, 16'd1, DIR_READ);
                add_byte(CMD_STATUS3, 1'b1, 16'd1, DIR_READ);
            end
            KIND_ID: add_byte(CMD_READ_ID, 1'b1, 16'd3, DIR_READ);
            KIND_ENTER_PD: begin
                if (pd_armed) begin
                    add_empty(STATUS_OK);
                end else begin
                    add_byte(CMD_ENTER_PD, 1'b1, 16'd0, DIR_NONE);
                    pd_armed = 1'b1;
                end
            end
            KIND_RELEASE_PD: begin
                pd_armed = 1'b0;
                add_byte(CMD_RELEASE_PD, 1'b1, 16'd0, DIR_NONE);
            end
            KIND_POWER_LOST: begin
                pd_armed = 1'b0;
                add_empty(STATUS_OK);
            end
            default: ok = 1'b0;
        endcase
        if (!ok) begin
            req_hdrs.delete();
            add_empty(STATUS_INVALID);
        end
        h      = req_hdrs.pop_back();
        h.last = 1'b1;
        req_hdrs.push_back(h);
        foreach (req_hdrs[i]) begin
            expected_hdrs.push_back(req_hdrs[i]);
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_rsp want;
        logic bad;
        if (!i_rst_n) begin
            expected_hdrs.delete();
            pd_armed = 1'b0;
            pending  = 0;
        end else begin
            if (i_req_valid && i_req_ready) begin
                predict_headers(i_req);
            end
            if (i_hdr_valid && i_hdr_ready) begin
                if (expected_hdrs.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("%t unexpected result: valid=%0d byte=%02h end=%0d len=%0d dir=%0d status=%0d last=%0d",
                                 $realtime, i_hdr.byte_valid, i_hdr.tx_byte, i_hdr.frame_end,
                                 i_hdr.data_len, i_hdr.data_dir, i_hdr.result_status,
                                 i_hdr.last);
                    end
                    fail_count++;
                end else begin
                    want = expected_hdrs.pop_front();
                    bad  = (want.byte_valid    !== i_hdr.byte_valid)    ||
                           (want.tx_byte       !== i_hdr.tx_byte)       ||
                           (want.frame_end     !== i_hdr.frame_end)     ||
                           (want.data_len      !== i_hdr.data_len)      ||
                           (want.data_dir      !== i_hdr.data_dir)      ||
                           (want.result_status !== i_hdr.result_status) ||
                           (want.last          !== i_hdr.last);
                    if (bad) begin
                        if (fail_count < 10) begin
                            $display("%t mismatch: expected valid=%0d byte=%02h end=%0d len=%0d dir=%0d status=%0d last=%0d",
                                     $realtime, want.byte_valid, want.tx_byte, want.frame_end,
                                     want.data_len, want.data_dir, want.result_status,
                                     want.last);
                            $display("%t           actual   valid=%0d byte=%02h end=%0d len=%0d dir=%0d status=%0d last=%0d",
                                     $realtime, i_hdr.byte_valid, i_hdr.tx_byte,
                                     i_hdr.frame_end, i_hdr.data_len, i_hdr.data_dir,
                                     i_hdr.result_status, i_hdr.last);
                        end
                        fail_count++;
                    end
                end
            end
            pending = expected_hdrs.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// testbench top for the flash command sequencer: stimulus, result sink and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfcs_pkg::*;

    localparam int unsigned FLASH  = FLASH_BYTES_DEF;
    localparam int unsigned PAGE   = PAGE_BYTES_DEF;
    localparam int unsigned SECTOR = SECTOR_BYTES_DEF;
    localparam int unsigned BLOCK  = BLOCK_BYTES_DEF;

    // kind codes the block has no use for
    localparam logic [3:0] KIND_UNUSED_LO = 4'd13;
    localparam logic [3:0] KIND_UNUSED_HI = 4'd15;

    // random requests per idling phase and length of the long receiver hold-off
    localparam int PHASE_REQS = 115;
    localparam int HOLD_LEN   = 400;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    t_req req_data  = '0;
    logic hdr_valid;
    logic hdr_ready = 1'b0;
    t_rsp hdr_data;

    int send_idle_pct = 33;
    int recv_idle_pct = 59;
    int hold_cycles   = 0;
    int fail_count;
    int pending;

    // 12 ns period
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    spi_nor_flash_command_sequencer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_ready  (req_ready),
        .i_in_data   (req_data),
        .o_out_valid (hdr_valid),
        .i_out_ready (hdr_ready),
        .o_out_data  (hdr_data)
    );

    // watches both channels, predicts and compares
    flash_header_checker header_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req        (req_data),
        .i_hdr_valid  (hdr_valid),
        .i_hdr_ready  (hdr_ready),
        .i_hdr        (hdr_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result sink: random back-pressure, or a long hold-off counted down here
    initial begin : result_sink
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                hdr_ready <= 1'b0;
                hold_cycles--;
            end else begin
                hdr_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // run limit, well above the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_req make_req(logic [3:0] k, logic [23:0] a, logic [15:0] n);
        t_req r;
        r.kind    = k;
        r.address = a;
        r.length  = n;
        return r;
    endfunction

    // mostly well-formed requests with random content, the rest raw noise
    function automatic t_req random_request();
        t_req        r;
        int unsigned a;
        int unsigned room;
        r.kind    = 4'($urandom_range(15));
        r.address = 24'($urandom);
        r.length  = 16'($urandom);
        // raw noise: any kind, any address, any length; reaches the top address bits too
        if ($urandom_range(99) < 20) begin
            return r;
        end
        r.kind = 4'($urandom_range(KIND_POWER_LOST, KIND_WREN));
        case (r.kind)
            KIND_READ, KIND_FAST_READ: begin
                // a fair share right against the end of the flash
                if ($urandom_range(4) == 0) begin
                    a = FLASH - $urandom_range(300, 1);
                end else begin
                    a = $urandom_range(FLASH - 1);
                end
                room = FLASH - a;
                if (room > 65535) begin
                    room = 65535;
                end
                r.address = 24'(a);
                r.length  = 16'($urandom_range(room, 1));
            end
            KIND_PROGRAM: begin
                r.address = 24'($urandom_range(FLASH / PAGE - 1) * PAGE);
                r.length  = 16'(PAGE);
            end
            KIND_PART_PROG: begin
                // stay inside one page
                a         = $urandom_range(FLASH - 1);
                room      = PAGE - (a % PAGE);
                r.address = 24'(a);
                r.length  = 16'($urandom_range(room, 1));
            end
            KIND_SECT_ERASE: begin
                r.address = 24'($urandom_range(FLASH / SECTOR - 1) * SECTOR);
            end
            KIND_BLOCK_ERASE: begin
                r.address = 24'($urandom_range(FLASH / BLOCK - 1) * BLOCK);
            end
            default: begin
                // address and length do not matter for the other kinds
            end
        endcase
        return r;
    endfunction

    // offer one request, with a random idle gap first; valid stays high until accepted
    task automatic send_request(input t_req r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        @(negedge clk);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do begin
            @(posedge clk);
        end while (!req_ready);
    endtask

    // sender pauses until every predicted result has come back
    task automatic wait_all_results();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    // one phase of random requests; hold_at picks the request that starts a long hold-off
    task automatic random_phase(input int count, input int hold_at);
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) begin
                hold_cycles = HOLD_LEN;
            end
            send_request(random_request());
        end
    endtask

    initial begin : stimulus
        // reset held low at the start, released on a falling edge
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, every kind, each boundary case
        send_request(make_req(KIND_WREN,        24'h000000, 16'd0));
        send_request(make_req(KIND_READ,        24'h000000, 16'd1));
        // last byte of the flash, then one byte past its end
        send_request(make_req(KIND_READ,        24'h3FFFFF, 16'd1));
        send_request(make_req(KIND_READ,        24'h3FFFFF, 16'd2));
        // zero length read
        send_request(make_req(KIND_READ,        24'h001000, 16'd0));
        // longest read that ends exactly at the end of the flash
        send_request(make_req(KIND_FAST_READ,   24'h3F0001, 16'hFFFF));
        send_request(make_req(KIND_FAST_READ,   24'hFFFFFF, 16'hFFFF));
        // top page, then a page program off the page boundary
        send_request(make_req(KIND_PROGRAM,     24'h3FFF00, 16'd256));
        send_request(make_req(KIND_PROGRAM,     24'h000080, 16'd256));
        // single byte at the page end, then one that crosses into the next page
        send_request(make_req(KIND_PART_PROG,   24'h0000FF, 16'd1));
        send_request(make_req(KIND_PART_PROG,   24'h0000F0, 16'd17));
        send_request(make_req(KIND_SECT_ERASE,  24'h3FF000, 16'd0));
        send_request(make_req(KIND_SECT_ERASE,  24'h000800, 16'd0));
        // top block, then an aligned block just outside the flash
        send_request(make_req(KIND_BLOCK_ERASE, 24'h3F8000, 16'd0));
        send_request(make_req(KIND_BLOCK_ERASE, 24'h400000, 16'd0));
        send_request(make_req(KIND_CHIP_ERASE,  24'h000000, 16'd0));
        send_request(make_req(KIND_STATUS,      24'h000000, 16'd0));
        send_request(make_req(KIND_ID,          24'h000000, 16'd0));
        // power-down entry, repeated entry while armed, release, entry again, rail loss
        send_request(make_req(KIND_ENTER_PD,    24'h000000, 16'd0));
        send_request(make_req(KIND_ENTER_PD,    24'h000000, 16'd0));
        send_request(make_req(KIND_RELEASE_PD,  24'h000000, 16'd0));
        send_request(make_req(KIND_ENTER_PD,    24'h000000, 16'd0));
        send_request(make_req(KIND_POWER_LOST,  24'h000000, 16'd0));
        // kinds with no meaning
        send_request(make_req(KIND_UNUSED_LO,   24'h000000, 16'd0));
        send_request(make_req(KIND_UNUSED_HI,   24'hFFFFFF, 16'hFFFF));

        // sender idles more rarely than the receiver; one long receiver hold-off
        random_phase(PHASE_REQS, 50);
        wait_all_results();

        // the other way round
        send_idle_pct = 59;
        recv_idle_pct = 33;
        random_phase(PHASE_REQS, -1);
        wait_all_results();

        // full throughput, no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(PHASE_REQS, -1);
        wait_all_results();

        // room for any stray result after the last expected one
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sfcs_pkg.sv
rtl/sfcs_decode.sv
rtl/sfcs_emit.sv
rtl/spi_nor_flash_command_sequencer.sv
verif/flash_header_checker.sv
verif/tb_top.sv
